FILE: sv/grq_pkg.sv
// Shared types, constants and helper functions for the genotype row QC filter.
// Used by grq_div, genotype_row_qc_filter and grq_chk; depends on nothing else.
package grq_pkg;

    // Sample counts and fixed-point formats
    localparam int unsigned C_MAX_SAMPLES = 4096;
    localparam int unsigned C_CNT_W       = 13;  // one class counter, 0..MAX_SAMPLES
    localparam int unsigned C_SUM_W       = 14;  // called count and alt allele count
    localparam int unsigned C_MAF_W       = 17;  // Q1.16 threshold, 65536 = 1.0
    localparam int unsigned C_FRAC_W      = 16;  // fraction bits of Q1.16 and Q2.16
    localparam int unsigned C_DOSE_W      = 18;  // Q2.16 fill dosage
    localparam int unsigned C_PROD_W      = 32;  // threshold times twice the called count

    // Divider: one quotient bit per cycle
    localparam int unsigned C_DIV_STEPS   = 18;
    localparam int unsigned C_STEP_W      = 5;

    // Genotype codes
    typedef logic [1:0] t_genotype;
    localparam t_genotype GT_HOM_REF = 2'd0;
    localparam t_genotype GT_HET     = 2'd1;
    localparam t_genotype GT_HOM_ALT = 2'd2;
    localparam t_genotype GT_MISSING = 2'd3;

    // Configuration register indexes
    typedef logic t_cfg_idx;
    localparam t_cfg_idx CFG_MAF_THR = 1'b0;
    localparam t_cfg_idx CFG_MA_THR  = 1'b1;

    // Row sequencer states
    typedef enum logic [1:0] {
        ST_COUNT,
        ST_CALC,
        ST_DIV,
        ST_EMIT
    } t_state;

    // Divider request and status
    typedef struct packed {
        logic               start;
        logic [C_SUM_W-1:0] num;
        logic [C_SUM_W-1:0] den;
    } t_div_ctl;

    typedef struct packed {
        logic                done;
        logic [C_DOSE_W-1:0] quot;
    } t_div_stat;

    // Saturating increment: a counter at MAX_SAMPLES has its top bit set
    function automatic logic [C_CNT_W-1:0] sat_inc(input logic [C_CNT_W-1:0] c);
        logic [C_CNT_W-1:0] r;
        r = c[C_CNT_W-1] ? c : c + C_CNT_W'(1);
        return r;
    endfunction

    // Cap a sum at MAX_SAMPLES for reporting
    function automatic logic [C_CNT_W-1:0] sat_cap(input logic [C_SUM_W-1:0] v);
        logic [C_CNT_W-1:0] r;
        r = (v > C_SUM_W'(C_MAX_SAMPLES)) ? C_CNT_W'(C_MAX_SAMPLES) : v[C_CNT_W-1:0];
        return r;
    endfunction

endpackage

FILE: sv/grq_div.sv
// Radix-2 restoring divider: floor(num * 65536 / den), one quotient bit per cycle.
// Depends on grq_pkg. The quotient holds until the next start.
module grq_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  grq_pkg::t_div_ctl  i_ctl,
    output grq_pkg::t_div_stat o_stat
);

    logic [grq_pkg::C_SUM_W-1:0]  r_rem;
    logic [grq_pkg::C_SUM_W-1:0]  n_rem;
    logic [grq_pkg::C_DOSE_W-1:0] r_qn;
    logic [grq_pkg::C_DOSE_W-1:0] n_qn;
    logic [grq_pkg::C_SUM_W-1:0]  r_den;
    logic [grq_pkg::C_STEP_W-1:0] r_step;
    logic                         r_busy;
    logic                         r_done;
    logic [grq_pkg::C_SUM_W:0]    w_trial;
    logic [grq_pkg::C_SUM_W:0]    w_diff;
    logic                         w_fits;

    // Shared subtract-and-compare: one trial subtraction per cycle
    always_comb begin
        w_trial = {r_rem, r_qn[grq_pkg::C_DOSE_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_fits  = (w_trial >= {1'b0, r_den});
        n_rem   = w_fits ? w_diff[grq_pkg::C_SUM_W-1:0] : w_trial[grq_pkg::C_SUM_W-1:0];
        n_qn    = {r_qn[grq_pkg::C_DOSE_W-2:0], w_fits};
    end

    // Control: load on start, count down the steps, pulse done at the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == grq_pkg::C_STEP_W'(1));
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_step <= grq_pkg::C_STEP_W'(grq_pkg::C_DIV_STEPS);
            end else if (r_busy) begin
                r_step <= r_step - grq_pkg::C_STEP_W'(1);
                if (r_step == grq_pkg::C_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: numerator is num << 16; its top bits start the remainder
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= {2'b00, i_ctl.num[grq_pkg::C_SUM_W-1:2]};
            r_qn  <= {i_ctl.num[1:0], {grq_pkg::C_FRAC_W{1'b0}}};
            r_den <= i_ctl.den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_qn  <= n_qn;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.quot = r_qn;

endmodule

FILE: sv/genotype_row_qc_filter.sv
// Top level of the genotype row QC filter: class counters, row sequencer, verdict.
// Depends on grq_pkg and grq_div.
//
//  channel   direction  handshake                  payload
//  input     in         i_valid / o_stall          i_genotype, i_last_sample
//  result    out        o_valid / i_stall          o_keep, o_has_missing, o_fill_dosage,
//                                                  o_minor_allele_samples, o_called_samples
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A sample that does not end its row does not stall the input; one transfer per cycle is possible.
// A row-ending sample stalls the input until the result register is loaded: ST_CALC forms
// the sums and the threshold product and starts the one-bit-per-cycle divider, ST_DIV waits
// for the divider to finish the fill dosage while the verdict settles, and ST_EMIT loads
// the result register. The next sample transfers once the sequencer is back in ST_COUNT.
// A stalled result holds in the output register; the verdict waits for it to drain.
// Synchronous reset clears the counters, thresholds, sequencer state and the result valid flag.
module genotype_row_qc_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_genotype,
    input  logic                          i_last_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_keep,
    output logic                          o_has_missing,
    output logic [grq_pkg::C_DOSE_W-1:0]  o_fill_dosage,
    output logic [grq_pkg::C_CNT_W-1:0]   o_minor_allele_samples,
    output logic [grq_pkg::C_CNT_W-1:0]   o_called_samples,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [grq_pkg::C_MAF_W-1:0]   i_cfg_data
);

    grq_pkg::t_state              r_state;
    grq_pkg::t_state              n_state;

    logic [grq_pkg::C_MAF_W-1:0]  r_maf_thr;
    logic [grq_pkg::C_CNT_W-1:0]  r_ma_thr;

    logic [grq_pkg::C_CNT_W-1:0]  r_cnt_ref;
    logic [grq_pkg::C_CNT_W-1:0]  r_cnt_het;
    logic [grq_pkg::C_CNT_W-1:0]  r_cnt_alt;
    logic                         r_missing;
    logic [grq_pkg::C_CNT_W-1:0]  n_cnt_ref;
    logic [grq_pkg::C_CNT_W-1:0]  n_cnt_het;
    logic [grq_pkg::C_CNT_W-1:0]  n_cnt_alt;
    logic                         n_missing;

    logic [grq_pkg::C_CNT_W-1:0]  r_snap_ref;
    logic [grq_pkg::C_CNT_W-1:0]  r_snap_het;
    logic [grq_pkg::C_CNT_W-1:0]  r_snap_alt;
    logic                         r_snap_missing;

    logic [grq_pkg::C_SUM_W-1:0]  w_n;
    logic [grq_pkg::C_SUM_W-1:0]  w_alt;
    logic [grq_pkg::C_SUM_W:0]    w_two_n;
    logic [grq_pkg::C_SUM_W:0]    w_ref_alleles;
    logic [grq_pkg::C_SUM_W-1:0]  w_minor_alt;
    logic [grq_pkg::C_CNT_W-1:0]  w_hmin;
    logic [grq_pkg::C_SUM_W-1:0]  w_minor_s;

    logic [grq_pkg::C_SUM_W-1:0]  r_n;
    logic [grq_pkg::C_SUM_W-1:0]  r_minor_alt;
    logic [grq_pkg::C_SUM_W-1:0]  r_minor_s;
    logic [grq_pkg::C_PROD_W-1:0] r_prod;
    logic                         r_keep_pend;

    logic                         w_in_xfer;
    logic                         w_out_xfer;
    logic                         w_load_out;
    logic                         w_row_end;

    grq_pkg::t_div_ctl            w_div_ctl;
    grq_pkg::t_div_stat           w_div_stat;

    logic                         r_valid;
    logic                         r_keep;
    logic                         r_has_missing;
    logic [grq_pkg::C_DOSE_W-1:0] r_fill_dosage;
    logic [grq_pkg::C_CNT_W-1:0]  r_ma_samples;
    logic [grq_pkg::C_CNT_W-1:0]  r_called;

    // Handshakes
    assign o_stall     = (r_state != grq_pkg::ST_COUNT);
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_valid && !o_stall;
    assign w_out_xfer  = r_valid && !i_stall;
    assign w_row_end   = w_in_xfer && i_last_sample;
    assign w_load_out  = (r_state == grq_pkg::ST_EMIT) && (!r_valid || w_out_xfer);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maf_thr <= '0;
            r_ma_thr  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                grq_pkg::CFG_MAF_THR: r_maf_thr <= i_cfg_data;
                grq_pkg::CFG_MA_THR:  r_ma_thr  <= i_cfg_data[grq_pkg::C_CNT_W-1:0];
                default:              r_maf_thr <= r_maf_thr;
            endcase
        end
    end

    // Count the incoming sample into its class
    always_comb begin
        n_cnt_ref = r_cnt_ref;
        n_cnt_het = r_cnt_het;
        n_cnt_alt = r_cnt_alt;
        n_missing = r_missing;
        case (i_genotype)
            grq_pkg::GT_HOM_REF: n_cnt_ref = grq_pkg::sat_inc(r_cnt_ref);
            grq_pkg::GT_HET:     n_cnt_het = grq_pkg::sat_inc(r_cnt_het);
            grq_pkg::GT_HOM_ALT: n_cnt_alt = grq_pkg::sat_inc(r_cnt_alt);
            default:             n_missing = 1'b1;
        endcase
    end

    // Advance the counters; clear them at row end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_ref <= '0;
            r_cnt_het <= '0;
            r_cnt_alt <= '0;
            r_missing <= 1'b0;
        end else if (w_row_end) begin
            r_cnt_ref <= '0;
            r_cnt_het <= '0;
            r_cnt_alt <= '0;
            r_missing <= 1'b0;
        end else if (w_in_xfer) begin
            r_cnt_ref <= n_cnt_ref;
            r_cnt_het <= n_cnt_het;
            r_cnt_alt <= n_cnt_alt;
            r_missing <= n_missing;
        end
    end

    // Capture the finished row's counts
    always_ff @(posedge i_clk) begin
        if (w_row_end) begin
            r_snap_ref     <= n_cnt_ref;
            r_snap_het     <= n_cnt_het;
            r_snap_alt     <= n_cnt_alt;
            r_snap_missing <= n_missing;
        end
    end

    // Row sums from the captured counts
    always_comb begin
        w_n           = grq_pkg::C_SUM_W'(r_snap_ref) + grq_pkg::C_SUM_W'(r_snap_het)
                      + grq_pkg::C_SUM_W'(r_snap_alt);
        w_alt         = grq_pkg::C_SUM_W'(r_snap_het) + {r_snap_alt, 1'b0};
        w_two_n       = {w_n, 1'b0};
        w_ref_alleles = w_two_n - {1'b0, w_alt};
        w_minor_alt   = (w_alt < w_ref_alleles[grq_pkg::C_SUM_W-1:0]
                         && !w_ref_alleles[grq_pkg::C_SUM_W])
                      ? w_alt : w_ref_alleles[grq_pkg::C_SUM_W-1:0];
        w_hmin        = (r_snap_ref < r_snap_alt) ? r_snap_ref : r_snap_alt;
        w_minor_s     = grq_pkg::C_SUM_W'(r_snap_het) + grq_pkg::C_SUM_W'(w_hmin);
    end

    // Register the sums and the threshold product
    always_ff @(posedge i_clk) begin
        if (r_state == grq_pkg::ST_CALC) begin
            r_n         <= w_n;
            r_minor_alt <= w_minor_alt;
            r_minor_s   <= w_minor_s;
            r_prod      <= grq_pkg::C_PROD_W'(r_maf_thr * w_two_n);
        end
    end

    // Settle the verdict while the divider runs
    always_ff @(posedge i_clk) begin
        if (r_state == grq_pkg::ST_DIV) begin
            r_keep_pend <= (r_n != '0)
                && (grq_pkg::C_PROD_W'({r_minor_alt, {grq_pkg::C_FRAC_W{1'b0}}}) >= r_prod)
                && (r_minor_s >= grq_pkg::C_SUM_W'(r_ma_thr));
        end
    end

    // Fill dosage: alt alleles * 65536 / called samples
    assign w_div_ctl.start = (r_state == grq_pkg::ST_CALC);
    assign w_div_ctl.num   = w_alt;
    assign w_div_ctl.den   = w_n;

    grq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .o_stat  (w_div_stat)
    );

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= grq_pkg::ST_COUNT;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            grq_pkg::ST_COUNT: if (w_row_end) n_state = grq_pkg::ST_CALC;
            grq_pkg::ST_CALC:  n_state = grq_pkg::ST_DIV;
            grq_pkg::ST_DIV:   if (w_div_stat.done) n_state = grq_pkg::ST_EMIT;
            grq_pkg::ST_EMIT:  if (w_load_out) n_state = grq_pkg::ST_COUNT;
            default:           n_state = grq_pkg::ST_COUNT;
        endcase
    end

    // Output register: load the verdict, drop valid on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load_out) begin
            r_valid <= 1'b1;
        end else if (w_out_xfer) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_keep        <= r_keep_pend;
            r_has_missing <= r_snap_missing;
            r_fill_dosage <= (r_n != '0) ? w_div_stat.quot : '0;
            r_ma_samples  <= grq_pkg::sat_cap(r_minor_s);
            r_called      <= grq_pkg::sat_cap(r_n);
        end
    end

    assign o_valid                = r_valid;
    assign o_keep                 = r_keep;
    assign o_has_missing          = r_has_missing;
    assign o_fill_dosage          = r_fill_dosage;
    assign o_minor_allele_samples = r_ma_samples;
    assign o_called_samples       = r_called;

endmodule

FILE: sv/grq_chk.sv
// Port-level checker for genotype_row_qc_filter, attached with a bind below.
// Depends on grq_pkg.
module grq_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_keep,
    input logic [grq_pkg::C_DOSE_W-1:0]  o_fill_dosage,
    input logic [grq_pkg::C_CNT_W-1:0]   o_minor_allele_samples,
    input logic [grq_pkg::C_CNT_W-1:0]   o_called_samples
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_fill_dosage) && $stable(o_keep)
                               && $stable(o_called_samples))
        else $error("stalled result changed");

    // A kept row has called samples
    a_keep_called: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_keep |-> o_called_samples != '0)
        else $error("row kept with no called sample");

    // Minor-allele samples never exceed called samples
    a_minor_le_called: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_minor_allele_samples <= o_called_samples)
        else $error("minor allele samples above called samples");

    // No called sample gives zero dosage
    a_dose_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_called_samples == '0 |-> o_fill_dosage == '0)
        else $error("nonzero dosage on empty row");

    // Dosage stays within two alt alleles
    a_dose_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_fill_dosage <= grq_pkg::C_DOSE_W'(2 << grq_pkg::C_FRAC_W))
        else $error("dosage above 2.0");

endmodule

bind genotype_row_qc_filter grq_chk u_grq_chk (.*);
